/* hdl/swerve_module_vector_to_steer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the swerve steering block
// Immediate-consequence and next-cycle property helpers with $error reporting.
// ----------------------------------------------------------------------------
`ifndef SWERVE_MODULE_VECTOR_TO_STEER_ASSERT_SVH
`define SWERVE_MODULE_VECTOR_TO_STEER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SWMV_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swmv assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define SWMV_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swmv assertion failed");

`endif

/* hdl/swmv_pkg.sv */
// ----------------------------------------------------------------------------
// swmv_pkg
// Widths, constants and table functions shared by the swerve steering block.
// ----------------------------------------------------------------------------
package swmv_pkg;

  localparam int VEL_W   = 16;
  localparam int FB_W    = 32;
  localparam int SPD_W   = 17;
  localparam int ANG_W   = 48;
  localparam int RATIO_W = 16;
  localparam int OFS_W   = 32;
  localparam int CFG_W   = 32;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int TABLE_LEN           = 24;

  // CORDIC datapath width: inputs are scaled by 2^14 and grow by the gain.
  localparam int CX_W      = 34;
  localparam int CX_SHIFT  = 14;

  // Divider retires this many quotient bits per stage.
  localparam int DIV_BITS  = 4;

  // Square root: one result bit per iteration, two iterations per stage.
  localparam int SQ_W      = 32;
  localparam int SQ_ITERS  = 16;
  localparam int SQ_PER    = 2;
  localparam int SQ_LAT    = SQ_ITERS / SQ_PER + 3;

  // Angle reduction: conditional subtracts per stage.
  localparam int MOD_PER   = 2;

  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CFG_STEER_RATIO  = 1'b0,
    CFG_STEER_OFFSET = 1'b1
  } cfg_idx_t;

  // Width of the signed quotient produced by the divider.
  function automatic int div_qw(input int f);
    return ((FB_W + f + DIV_BITS - 1) / DIV_BITS) * DIV_BITS + 1;
  endfunction

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Rescale a Q2.30 angle to f fraction bits, rounding to nearest.
  function automatic logic [31:0] q30_to_f(input logic [31:0] t, input int f);
    logic [32:0] sum;
    sum = {1'b0, t} + (33'd1 << (30 - f - 1));
    return 32'(sum >> (30 - f));
  endfunction

  // Saturate a wide signed value to the angle range.
  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [63:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 64'(ANG_MAX)) begin
      r = ANG_MAX;
    end else if (v < 64'(ANG_MIN)) begin
      r = ANG_MIN;
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/swmv_dly.sv */
// ----------------------------------------------------------------------------
// swmv_dly
// Enabled delay line used to align the parallel units of the pipeline.
// ----------------------------------------------------------------------------
module swmv_dly #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  if (D == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [W-1:0] tap_r [0:D-1];
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= din;
        for (int i = 1; i < D; i++) begin
          tap_r[i] <= tap_r[i-1];
        end
      end
    end
    assign dout = tap_r[D-1];
  end

endmodule

/* hdl/swmv_div.sv */
// ----------------------------------------------------------------------------
// swmv_div
// Pipelined restoring divider: round(feedback * 2^F / ratio), half away from 0.
// ----------------------------------------------------------------------------
module swmv_div #(
  parameter int F = swmv_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [swmv_pkg::FB_W-1:0]       fb,
  input  logic [swmv_pkg::RATIO_W-1:0]           ratio,
  output logic signed [swmv_pkg::div_qw(F)-1:0]  q
);
  import swmv_pkg::*;

  localparam int NS  = (FB_W + F + DIV_BITS - 1) / DIV_BITS;
  localparam int NWP = NS * DIV_BITS;

  logic [RATIO_W-1:0] rr;
  logic [FB_W-1:0]    mag;

  logic [NWP-1:0]     n_r   [0:NS];
  logic [NWP-1:0]     q_r   [0:NS];
  logic [RATIO_W-1:0] rem_r [0:NS];
  logic               neg_r [0:NS];

  // A ratio of zero divides by one.
  assign rr  = (ratio == '0) ? {{(RATIO_W-1){1'b0}}, 1'b1} : ratio;
  assign mag = fb[FB_W-1] ? (~fb + 1'b1) : fb;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= (NWP'(mag) << F) + NWP'(rr >> 1);
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      neg_r[0] <= fb[FB_W-1];
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [NWP-1:0]     n_c;
    logic [NWP-1:0]     q_c;
    logic [RATIO_W-1:0] rem_c;
    logic [RATIO_W:0]   t;

    always_comb begin
      n_c   = n_r[g];
      q_c   = q_r[g];
      rem_c = rem_r[g];
      t     = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        t   = {rem_c, n_c[NWP-1]};
        n_c = n_c << 1;
        if (t >= {1'b0, rr}) begin
          t   = t - {1'b0, rr};
          q_c = {q_c[NWP-2:0], 1'b1};
        end else begin
          q_c = {q_c[NWP-2:0], 1'b0};
        end
        rem_c = t[RATIO_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[g+1]   <= n_c;
        q_r[g+1]   <= q_c;
        rem_r[g+1] <= rem_c;
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  assign q = neg_r[NS] ? -$signed({1'b0, q_r[NS]}) : $signed({1'b0, q_r[NS]});

endmodule

/* hdl/swmv_sqrt.sv */
// ----------------------------------------------------------------------------
// swmv_sqrt
// Pipelined vector magnitude: squares, sum, digit-by-digit root, rounding.
// ----------------------------------------------------------------------------
module swmv_sqrt (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [swmv_pkg::VEL_W-1:0]  vx,
  input  logic signed [swmv_pkg::VEL_W-1:0]  vy,
  output logic [swmv_pkg::SPD_W-1:0]         speed
);
  import swmv_pkg::*;

  localparam int NS = SQ_ITERS / SQ_PER;

  logic [SQ_W-1:0] px_r;
  logic [SQ_W-1:0] py_r;
  logic [SQ_W-1:0] s_r [0:NS];
  logic [SQ_W-1:0] r_r [0:NS];
  logic [SPD_W-1:0] spd_r;

  // The operands are widened before the multiply so the square keeps all its bits.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= SQ_W'(SQ_W'(vx) * SQ_W'(vx));
      py_r   <= SQ_W'(SQ_W'(vy) * SQ_W'(vy));
      s_r[0] <= px_r + py_r;
      r_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [SQ_W-1:0] s_c;
    logic [SQ_W-1:0] r_c;
    logic [SQ_W:0]   tr;
    logic [SQ_W-1:0] bitv;

    always_comb begin
      s_c  = s_r[g];
      r_c  = r_r[g];
      tr   = '0;
      bitv = '0;
      for (int j = 0; j < SQ_PER; j++) begin
        bitv = SQ_W'(1) << (SQ_W - 2 - 2 * (g * SQ_PER + j));
        tr   = {1'b0, r_c} + {1'b0, bitv};
        if ({1'b0, s_c} >= tr) begin
          s_c = s_c - tr[SQ_W-1:0];
          r_c = (r_c >> 1) + bitv;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[g+1] <= s_c;
        r_r[g+1] <= r_c;
      end
    end
  end

  // The remainder exceeding the root means the exact root is past the half.
  always_ff @(posedge clk) begin
    if (en) begin
      spd_r <= (s_r[NS] > r_r[NS]) ? SPD_W'(r_r[NS] + 1'b1) : SPD_W'(r_r[NS]);
    end
  end

  assign speed = spd_r;

endmodule

/* hdl/swmv_cordic.sv */
// ----------------------------------------------------------------------------
// swmv_cordic
// Unrolled vectoring CORDIC giving the direction of the velocity vector.
// ----------------------------------------------------------------------------
module swmv_cordic #(
  parameter int F = swmv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int N = swmv_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [swmv_pkg::VEL_W-1:0]  vx,
  input  logic signed [swmv_pkg::VEL_W-1:0]  vy,
  output logic signed [F+3:0]                z
);
  import swmv_pkg::*;

  localparam int ZW = F + 4;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(q30_to_f(PI_Q30, F));

  logic signed [CX_W-1:0] x_r [0:N];
  logic signed [CX_W-1:0] y_r [0:N];
  logic signed [ZW-1:0]   z_r [0:N];
  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;

  assign xs = CX_W'(vx) <<< CX_SHIFT;
  assign ys = CX_W'(vy) <<< CX_SHIFT;

  // Vectors in the left half plane are turned by pi first.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= xs[CX_W-1] ? -xs : xs;
      y_r[0] <= xs[CX_W-1] ? -ys : ys;
      z_r[0] <= xs[CX_W-1] ? PI_Z : '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_Z = ZW'(q30_to_f(atan_q30(g), F));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[g][CX_W-1]) begin
          x_r[g+1] <= x_r[g] + (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] - (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] + ATAN_Z;
        end else begin
          x_r[g+1] <= x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= y_r[g] + (x_r[g] >>> g);
          z_r[g+1] <= z_r[g] - ATAN_Z;
        end
      end
    end
  end

  assign z = z_r[N];

endmodule

/* hdl/swmv_wrap.sv */
// ----------------------------------------------------------------------------
// swmv_wrap
// Current angle, error reduction modulo 2*pi, shortest turn and output stage.
// ----------------------------------------------------------------------------
module swmv_wrap #(
  parameter int F = swmv_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [swmv_pkg::div_qw(F)-1:0]  q,
  input  logic signed [swmv_pkg::OFS_W-1:0]      offset,
  input  logic [swmv_pkg::SPD_W-1:0]             speed,
  input  logic signed [F+3:0]                    z,
  output logic signed [swmv_pkg::SPD_W-1:0]      drive_speed,
  output logic signed [swmv_pkg::ANG_W-1:0]      steer_target,
  output logic signed [swmv_pkg::ANG_W-1:0]      current_angle,
  output logic                                   reversed
);
  import swmv_pkg::*;

  localparam int ZW     = F + 4;
  localparam int DW     = ANG_W + 2;
  localparam int MW     = ANG_W + 3;
  localparam int P      = ANG_W - 1 - F;
  localparam int MOD_ST = (P + MOD_PER) / MOD_PER;
  localparam logic signed [ZW-1:0] PI_Z     = ZW'(q30_to_f(PI_Q30, F));
  localparam logic signed [ZW-1:0] TWO_PI_Z = PI_Z <<< 1;
  localparam logic signed [ZW-1:0] HALF_PI_Z = PI_Z >>> 1;
  localparam logic [MW-1:0] TWO_PI_M = MW'(TWO_PI_Z);
  localparam logic [MW-1:0] BIAS_M   = TWO_PI_M << P;

  logic signed [ANG_W-1:0] cur1_r;
  logic [SPD_W-1:0]        spd1_r;
  logic signed [ZW-1:0]    z1_r;
  logic signed [DW-1:0]    d_c;

  logic [MW-1:0]           m_r   [0:MOD_ST];
  logic signed [ANG_W-1:0] cur_r [0:MOD_ST];
  logic [SPD_W-1:0]        spd_r [0:MOD_ST];

  logic signed [ZW-1:0]    mm;
  logic signed [ZW-1:0]    dw;
  logic signed [ZW-1:0]    dd;
  logic                    rev_c;

  logic signed [SPD_W-1:0] drive_speed_r;
  logic signed [ANG_W-1:0] steer_target_r;
  logic signed [ANG_W-1:0] current_angle_r;
  logic                    reversed_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cur1_r <= sat_ang(64'(q) - 64'(offset));
      spd1_r <= speed;
      z1_r   <= z;
    end
  end

  // A negative error is lifted by a multiple of 2*pi so the reduction is unsigned.
  assign d_c = DW'(z1_r) - DW'(cur1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]   <= d_c[DW-1] ? (MW'(d_c) + BIAS_M) : MW'(d_c);
      cur_r[0] <= cur1_r;
      spd_r[0] <= spd1_r;
    end
  end

  for (genvar g = 0; g < MOD_ST; g++) begin : g_mod
    logic [MW-1:0] m_c;
    always_comb begin
      m_c = m_r[g];
      for (int j = 0; j < MOD_PER; j++) begin
        if (P - (g * MOD_PER + j) >= 0) begin
          if (m_c >= (TWO_PI_M << (P - (g * MOD_PER + j)))) begin
            m_c = m_c - (TWO_PI_M << (P - (g * MOD_PER + j)));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[g+1]   <= m_c;
        cur_r[g+1] <= cur_r[g];
        spd_r[g+1] <= spd_r[g];
      end
    end
  end

  // Map [0, 2*pi) onto (-pi, pi], then take the shorter way round.
  always_comb begin
    mm    = ZW'(m_r[MOD_ST]);
    dw    = (mm > PI_Z) ? (mm - TWO_PI_Z) : mm;
    dd    = dw;
    rev_c = 1'b0;
    if (dw > HALF_PI_Z) begin
      dd    = dw - PI_Z;
      rev_c = 1'b1;
    end else if (dw < -HALF_PI_Z) begin
      dd    = dw + PI_Z;
      rev_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      current_angle_r <= cur_r[MOD_ST];
      if (spd_r[MOD_ST] == '0) begin
        drive_speed_r  <= '0;
        steer_target_r <= cur_r[MOD_ST];
        reversed_r     <= 1'b0;
      end else begin
        drive_speed_r  <= rev_c ? -$signed(spd_r[MOD_ST]) : $signed(spd_r[MOD_ST]);
        steer_target_r <= sat_ang(64'(cur_r[MOD_ST]) + 64'(dd));
        reversed_r     <= rev_c;
      end
    end
  end

  assign drive_speed   = drive_speed_r;
  assign steer_target  = steer_target_r;
  assign current_angle = current_angle_r;
  assign reversed      = reversed_r;

endmodule

/* hdl/swerve_module_vector_to_steer.sv */
// ----------------------------------------------------------------------------
// swerve_module_vector_to_steer
// Turns a wheel velocity vector and steering feedback into a steer command.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel carries a velocity vector and the
// steering motor position. Exactly one transfer leaves on the output channel
// for each one that enters, in order, with the drive speed, the target and
// measured steer angles (Q.F radians) and the reversal flag.
// The longest of the three parallel units (the angle divider, the square root
// or the CORDIC chain) and the modulo 2*pi reduction set the pipeline depth.
// One transfer is taken every cycle while the output is not stalled.
// The whole pipeline advances together: while the output holds a result that
// the receiver does not take, every stage freezes and in_ready drops, so no
// item is lost or repeated. While a result waits, in_ready follows out_ready.
// Reset (synchronous, active low) clears all valid bits and loads the default
// ratio of 191 and an offset of zero. Configuration writes take effect at the
// next edge and should be made while no transfer is in flight.
// ----------------------------------------------------------------------------
`include "swerve_module_vector_to_steer_assert.svh"

module swerve_module_vector_to_steer #(
  parameter int ANGLE_FRAC_BITS = swmv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = swmv_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [swmv_pkg::VEL_W-1:0]  in_velocity_x,
  input  logic signed [swmv_pkg::VEL_W-1:0]  in_velocity_y,
  input  logic signed [swmv_pkg::FB_W-1:0]   in_steer_feedback,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [swmv_pkg::SPD_W-1:0]  out_drive_speed,
  output logic signed [swmv_pkg::ANG_W-1:0]  out_steer_target,
  output logic signed [swmv_pkg::ANG_W-1:0]  out_current_angle,
  output logic                               out_reversed,
  input  logic                               cfg_we,
  input  swmv_pkg::cfg_idx_t                 cfg_index,
  input  logic [swmv_pkg::CFG_W-1:0]         cfg_wdata
);
  import swmv_pkg::*;

  // Stage counts of the parallel units; the shorter ones are padded to match.
  localparam int F        = ANGLE_FRAC_BITS;
  localparam int NST      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int ZW       = F + 4;
  localparam int QW       = div_qw(F);
  localparam int DIV_LAT  = (FB_W + F + DIV_BITS - 1) / DIV_BITS + 1;
  localparam int COR_LAT  = NST + 1;
  localparam int LA0      = (DIV_LAT > SQ_LAT) ? DIV_LAT : SQ_LAT;
  localparam int LA       = (LA0 > COR_LAT) ? LA0 : COR_LAT;
  localparam int MOD_ST   = (ANG_W - F + MOD_PER - 1) / MOD_PER;
  localparam int LT       = LA + MOD_ST + 3;

  logic [RATIO_W-1:0]      ratio_r;
  logic signed [OFS_W-1:0] offset_r;
  logic [LT-1:0]           vld_r;
  logic                    adv;

  logic signed [QW-1:0]    q_raw;
  logic signed [QW-1:0]    q_al;
  logic [SPD_W-1:0]        spd_raw;
  logic [SPD_W-1:0]        spd_al;
  logic signed [ZW-1:0]    z_raw;
  logic signed [ZW-1:0]    z_al;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_W'(191);
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEER_RATIO:  ratio_r  <= cfg_wdata[RATIO_W-1:0];
        CFG_STEER_OFFSET: offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Every stage moves when the output register is empty or being drained.
  assign adv       = !vld_r[LT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[LT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LT-2:0], in_valid};
    end
  end

  swmv_div #(.F(F)) u_div (
    .clk   (clk),
    .en    (adv),
    .fb    (in_steer_feedback),
    .ratio (ratio_r),
    .q     (q_raw)
  );

  swmv_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .vx    (in_velocity_x),
    .vy    (in_velocity_y),
    .speed (spd_raw)
  );

  swmv_cordic #(.F(F), .N(NST)) u_cordic (
    .clk (clk),
    .en  (adv),
    .vx  (in_velocity_x),
    .vy  (in_velocity_y),
    .z   (z_raw)
  );

  swmv_dly #(.W(QW), .D(LA - DIV_LAT)) u_dly_q (
    .clk (clk), .en (adv), .din (q_raw), .dout (q_al)
  );

  swmv_dly #(.W(SPD_W), .D(LA - SQ_LAT)) u_dly_spd (
    .clk (clk), .en (adv), .din (spd_raw), .dout (spd_al)
  );

  swmv_dly #(.W(ZW), .D(LA - COR_LAT)) u_dly_z (
    .clk (clk), .en (adv), .din (z_raw), .dout (z_al)
  );

  swmv_wrap #(.F(F)) u_wrap (
    .clk           (clk),
    .en            (adv),
    .q             (q_al),
    .offset        (offset_r),
    .speed         (spd_al),
    .z             (z_al),
    .drive_speed   (out_drive_speed),
    .steer_target  (out_steer_target),
    .current_angle (out_current_angle),
    .reversed      (out_reversed)
  );

  // A reversed result always carries a nonzero, negative drive speed.
  `SWMV_ASSERT_IMP(a_rev_neg, clk, rst_n, out_valid && out_reversed,
                   out_drive_speed[SPD_W-1] && (out_drive_speed != '0))
  // A positive or zero speed means no reversal took place.
  `SWMV_ASSERT_IMP(a_fwd_flag, clk, rst_n, out_valid && !out_drive_speed[SPD_W-1],
                   !out_reversed)
  // A zero vector holds the measured angle.
  `SWMV_ASSERT_IMP(a_zero_hold, clk, rst_n, out_valid && (out_drive_speed == '0),
                   out_steer_target == out_current_angle)
  // An accepted transfer occupies the first pipeline slot in the next cycle.
  `SWMV_ASSERT_NXT(a_enter, clk, rst_n, in_valid && in_ready, vld_r[0])

endmodule
